// File: design/pic_pkg.sv
// Shared constants and types for the point-in-primitive classifier.
// No dependencies; other files refer to it by scoped names.
package pic_pkg;

    // Default widths for the top-level parameters
    localparam int COORD_WIDTH_DEF = 20;
    localparam int QUAT_WIDTH_DEF  = 16;

    // Number of group bits that may be set in the group byte
    localparam int GROUP_COUNT = 8;
    localparam int GROUP_BYTE  = 8;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_CENTER_X   = 3'd0;
    localparam logic [2:0] REG_CENTER_Y   = 3'd1;
    localparam logic [2:0] REG_CENTER_Z   = 3'd2;
    localparam logic [2:0] REG_ROT_QUAT   = 3'd3;
    localparam logic [2:0] REG_HALF_X     = 3'd4;
    localparam logic [2:0] REG_HALF_Y     = 3'd5;
    localparam logic [2:0] REG_HALF_Z     = 3'd6;
    localparam logic [2:0] REG_SHAPE_MODE = 3'd7;

    localparam logic [63:0] QUAT_RESET  = 64'h4000_0000_0000_0000;
    localparam logic [4:0]  SHAPE_RESET = 5'd3;

    // Shape codes
    localparam logic [1:0] SHAPE_BOX  = 2'd0;
    localparam logic [1:0] SHAPE_ELL  = 2'd1;
    localparam logic [1:0] SHAPE_CYL  = 2'd2;
    localparam logic [1:0] SHAPE_NONE = 2'd3;

    // Static primitive control taken from the registers
    typedef struct packed {
        logic       enabled;
        logic [1:0] shape;
        logic [2:0] gbit;
    } t_ctl;

    // Per-axis bounds flags of one item
    typedef struct packed {
        logic in_x;
        logic in_y;
        logic in_z;
    } t_bnd;

endpackage

// File: design/pic_in_if.sv
// Input channel of the classifier: valid/ready handshake with one point item.
// Depends on nothing.
interface pic_in_if #(
    parameter int CW = 20
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic [7:0]           groups_in;

    modport source(output valid, output point_x, output point_y, output point_z,
                   output groups_in, input ready);
    modport sink(input valid, input point_x, input point_y, input point_z,
                 input groups_in, output ready);
endinterface

// File: design/pic_out_if.sv
// Output channel of the classifier: valid/ready handshake with one result item.
// Depends on nothing.
interface pic_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] groups_out;
    logic       inside_res;

    modport source(output valid, output groups_out, output inside_res, input ready);
    modport sink(input valid, input groups_out, input inside_res, output ready);
endinterface

// File: design/point_in_primitive_classifier.sv
// Point-in-primitive classifier: one point item per cycle unless the output stalls;
// each item passes 4 rotate/bounds stages, then 5 product/compare stages.
// A stalled output holds the whole pipeline in place; input ready is low only then.
// Constants derived from the registers follow a write through their own registers.
// Synchronous active-low reset empties the pipeline and loads register defaults.
module point_in_primitive_classifier #(
    parameter int COORD_WIDTH = pic_pkg::COORD_WIDTH_DEF,
    parameter int QUAT_WIDTH  = pic_pkg::QUAT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pic_in_if.sink      i_pt,
    pic_out_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    localparam int HW = COORD_WIDTH - 1;

    logic signed [COORD_WIDTH-1:0]  ctr_x, ctr_y, ctr_z;
    logic [HW-1:0]                  half_x, half_y, half_z;
    logic signed [2*QUAT_WIDTH+1:0] mat [9];
    logic [4*HW-1:0]                kx, ky, kz;
    logic [6*HW-1:0]                rhs;
    pic_pkg::t_ctl                  ctl;
    logic                           adv;
    logic                           rot_v;
    logic [7:0]                     rot_g;
    logic [HW-1:0]                  rot_m [3];
    pic_pkg::t_bnd                  rot_b;
    logic                           out_v;

    // Move the pipeline whenever the output slot is free or being taken
    assign adv        = !out_v || o_res.ready;
    assign i_pt.ready = adv;
    assign o_res.valid = out_v;

    pic_cfg #(.CW(COORD_WIDTH), .QW(QUAT_WIDTH)) u_cfg (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .o_ctr_x(ctr_x), .o_ctr_y(ctr_y), .o_ctr_z(ctr_z),
        .o_half_x(half_x), .o_half_y(half_y), .o_half_z(half_z),
        .o_mat(mat), .o_kx(kx), .o_ky(ky), .o_kz(kz), .o_rhs(rhs), .o_ctl(ctl)
    );

    pic_rot #(.CW(COORD_WIDTH), .QW(QUAT_WIDTH)) u_rot (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv), .i_valid(i_pt.valid),
        .i_px(i_pt.point_x), .i_py(i_pt.point_y), .i_pz(i_pt.point_z),
        .i_grp(i_pt.groups_in),
        .i_ctr_x(ctr_x), .i_ctr_y(ctr_y), .i_ctr_z(ctr_z),
        .i_half_x(half_x), .i_half_y(half_y), .i_half_z(half_z), .i_mat(mat),
        .o_valid(rot_v), .o_grp(rot_g), .o_m(rot_m), .o_bnd(rot_b)
    );

    pic_test #(.CW(COORD_WIDTH)) u_test (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_adv(adv), .i_valid(rot_v),
        .i_grp(rot_g), .i_m(rot_m), .i_bnd(rot_b),
        .i_kx(kx), .i_ky(ky), .i_kz(kz), .i_rhs(rhs), .i_ctl(ctl),
        .o_valid(out_v), .o_grp(o_res.groups_out), .o_inside(o_res.inside_res)
    );
endmodule

// File: design/pic_mul.sv
// Two-stage unsigned multiplier: operand A is cut into chunks, partial products
// are registered, then shifted and summed. Depends on nothing.
module pic_mul #(
    parameter int A_W = 76,
    parameter int B_W = 38,
    parameter int C_W = 19
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic [A_W+B_W-1:0] o_p
);
    localparam int N  = (A_W + C_W - 1) / C_W;
    localparam int PW = A_W + B_W;

    logic [N*C_W-1:0]   a_pad;
    logic [C_W+B_W-1:0] r_pp [N];
    logic [PW-1:0]      n_p;
    logic [PW-1:0]      r_p;

    assign a_pad = (N*C_W)'(i_a);

    // Form one partial product per chunk
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < N; i++) begin
                r_pp[i] <= a_pad[i*C_W +: C_W] * i_b;
            end
        end
    end

    // Align and add the partial products
    always_comb begin
        n_p = '0;
        for (int i = 0; i < N; i++) begin
            n_p = n_p + (PW'(r_pp[i]) << (i*C_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;
endmodule

// File: design/pic_cfg.sv
// Configuration registers behind the APB-style port, plus the constants the
// pipeline derives from them (rotation matrix, extent products). Uses pic_pkg, pic_mul.
module pic_cfg #(
    parameter int CW = pic_pkg::COORD_WIDTH_DEF,
    parameter int QW = pic_pkg::QUAT_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [5:0]               paddr,
    input  logic [63:0]              pwdata,
    output logic [63:0]              prdata,
    output logic                     pready,
    output logic signed [CW-1:0]     o_ctr_x,
    output logic signed [CW-1:0]     o_ctr_y,
    output logic signed [CW-1:0]     o_ctr_z,
    output logic [CW-2:0]            o_half_x,
    output logic [CW-2:0]            o_half_y,
    output logic [CW-2:0]            o_half_z,
    output logic signed [2*QW+1:0]   o_mat [9],
    output logic [4*(CW-1)-1:0]      o_kx,
    output logic [4*(CW-1)-1:0]      o_ky,
    output logic [4*(CW-1)-1:0]      o_kz,
    output logic [6*(CW-1)-1:0]      o_rhs,
    output pic_pkg::t_ctl            o_ctl
);
    localparam int HW = CW - 1;
    localparam int MW = 2*QW + 2;

    logic [CW-1:0] r_cx, r_cy, r_cz;
    logic [63:0]   r_quat;
    logic [HW-1:0] r_hx, r_hy, r_hz;
    logic [4:0]    r_mode;
    logic          wen;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wen    = psel && penable && pwrite;
    assign idx    = paddr[5:3];

    // Write registers at the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
            r_quat <= pic_pkg::QUAT_RESET;
            r_hx   <= '0;
            r_hy   <= '0;
            r_hz   <= '0;
            r_mode <= pic_pkg::SHAPE_RESET;
        end else if (wen) begin
            case (idx)
                pic_pkg::REG_CENTER_X:   r_cx   <= pwdata[CW-1:0];
                pic_pkg::REG_CENTER_Y:   r_cy   <= pwdata[CW-1:0];
                pic_pkg::REG_CENTER_Z:   r_cz   <= pwdata[CW-1:0];
                pic_pkg::REG_ROT_QUAT:   r_quat <= pwdata;
                pic_pkg::REG_HALF_X:     r_hx   <= pwdata[HW-1:0];
                pic_pkg::REG_HALF_Y:     r_hy   <= pwdata[HW-1:0];
                pic_pkg::REG_HALF_Z:     r_hz   <= pwdata[HW-1:0];
                pic_pkg::REG_SHAPE_MODE: r_mode <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (idx)
            pic_pkg::REG_CENTER_X:   prdata = 64'(r_cx);
            pic_pkg::REG_CENTER_Y:   prdata = 64'(r_cy);
            pic_pkg::REG_CENTER_Z:   prdata = 64'(r_cz);
            pic_pkg::REG_ROT_QUAT:   prdata = r_quat;
            pic_pkg::REG_HALF_X:     prdata = 64'(r_hx);
            pic_pkg::REG_HALF_Y:     prdata = 64'(r_hy);
            pic_pkg::REG_HALF_Z:     prdata = 64'(r_hz);
            pic_pkg::REG_SHAPE_MODE: prdata = 64'(r_mode);
            default:                 prdata = '0;
        endcase
    end

    assign o_ctr_x  = r_cx;
    assign o_ctr_y  = r_cy;
    assign o_ctr_z  = r_cz;
    assign o_half_x = r_hx;
    assign o_half_y = r_hy;
    assign o_half_z = r_hz;

    // Rotation matrix of the conjugate quaternion, one register level
    logic signed [QW-1:0]   qw, qx, qy, qz;
    logic signed [2*QW-1:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
    logic signed [MW-1:0]   n_mat [9];
    logic signed [MW-1:0]   r_mat [9];

    assign qw = r_quat[48 +: QW];
    assign qx = r_quat[32 +: QW];
    assign qy = r_quat[16 +: QW];
    assign qz = r_quat[0  +: QW];

    always_comb begin
        ww = qw * qw;
        xx = qx * qx;
        yy = qy * qy;
        zz = qz * qz;
        xy = qx * qy;
        xz = qx * qz;
        yz = qy * qz;
        wx = qw * qx;
        wy = qw * qy;
        wz = qw * qz;
        n_mat[0] = MW'(ww) + MW'(xx) - MW'(yy) - MW'(zz);
        n_mat[1] = (MW'(xy) + MW'(wz)) <<< 1;
        n_mat[2] = (MW'(xz) - MW'(wy)) <<< 1;
        n_mat[3] = (MW'(xy) - MW'(wz)) <<< 1;
        n_mat[4] = MW'(ww) - MW'(xx) + MW'(yy) - MW'(zz);
        n_mat[5] = (MW'(yz) + MW'(wx)) <<< 1;
        n_mat[6] = (MW'(xz) + MW'(wy)) <<< 1;
        n_mat[7] = (MW'(yz) - MW'(wx)) <<< 1;
        n_mat[8] = MW'(ww) - MW'(xx) - MW'(yy) + MW'(zz);
    end

    always_ff @(posedge i_clk) begin
        r_mat <= n_mat;
    end

    assign o_mat = r_mat;

    // Extent squares and their products, free running
    logic [2*HW-1:0] r_a2, r_b2, r_c2;
    logic [4*HW-1:0] ab, ac, bc;
    logic [6*HW-1:0] abc;

    always_ff @(posedge i_clk) begin
        r_a2 <= r_hx * r_hx;
        r_b2 <= r_hy * r_hy;
        r_c2 <= r_hz * r_hz;
    end

    pic_mul #(.A_W(2*HW), .B_W(2*HW), .C_W(HW)) u_mul_ab (
        .i_clk(i_clk), .i_en(1'b1), .i_a(r_a2), .i_b(r_b2), .o_p(ab)
    );
    pic_mul #(.A_W(2*HW), .B_W(2*HW), .C_W(HW)) u_mul_ac (
        .i_clk(i_clk), .i_en(1'b1), .i_a(r_a2), .i_b(r_c2), .o_p(ac)
    );
    pic_mul #(.A_W(2*HW), .B_W(2*HW), .C_W(HW)) u_mul_bc (
        .i_clk(i_clk), .i_en(1'b1), .i_a(r_b2), .i_b(r_c2), .o_p(bc)
    );
    pic_mul #(.A_W(4*HW), .B_W(2*HW), .C_W(HW)) u_mul_abc (
        .i_clk(i_clk), .i_en(1'b1), .i_a(ab), .i_b(r_c2), .o_p(abc)
    );

    // Pick the per-axis weights and the bound for ellipsoid or cylinder
    logic [4*HW-1:0] r_kx, r_ky, r_kz;
    logic [6*HW-1:0] r_rhs;

    always_ff @(posedge i_clk) begin
        if (r_mode[1:0] == pic_pkg::SHAPE_ELL) begin
            r_kx  <= bc;
            r_ky  <= ac;
            r_kz  <= ab;
            r_rhs <= abc;
        end else begin
            r_kx  <= (4*HW)'(r_b2);
            r_ky  <= (4*HW)'(r_a2);
            r_kz  <= '0;
            r_rhs <= (6*HW)'(ab);
        end
    end

    assign o_kx  = r_kx;
    assign o_ky  = r_ky;
    assign o_kz  = r_kz;
    assign o_rhs = r_rhs;

    assign o_ctl.enabled = (r_hx != '0) && (r_hy != '0) && (r_hz != '0)
                           && (r_mode[1:0] != pic_pkg::SHAPE_NONE);
    assign o_ctl.shape   = r_mode[1:0];
    assign o_ctl.gbit    = r_mode[4:2];
endmodule

// File: design/pic_rot.sv
// Front pipeline: offset from the centre, rotation, rounding and bounds test
// (four stages). Uses pic_pkg.
module pic_rot #(
    parameter int CW = pic_pkg::COORD_WIDTH_DEF,
    parameter int QW = pic_pkg::QUAT_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  logic                   i_valid,
    input  logic signed [CW-1:0]   i_px,
    input  logic signed [CW-1:0]   i_py,
    input  logic signed [CW-1:0]   i_pz,
    input  logic [7:0]             i_grp,
    input  logic signed [CW-1:0]   i_ctr_x,
    input  logic signed [CW-1:0]   i_ctr_y,
    input  logic signed [CW-1:0]   i_ctr_z,
    input  logic [CW-2:0]          i_half_x,
    input  logic [CW-2:0]          i_half_y,
    input  logic [CW-2:0]          i_half_z,
    input  logic signed [2*QW+1:0] i_mat [9],
    output logic                   o_valid,
    output logic [7:0]             o_grp,
    output logic [CW-2:0]          o_m [3],
    output pic_pkg::t_bnd          o_bnd
);
    localparam int HW = CW - 1;
    localparam int DW = CW + 1;
    localparam int MW = 2*QW + 2;
    localparam int PW = MW + DW;
    localparam int SW = PW + 2;
    localparam int K  = 2*(QW - 2);
    localparam int RW = SW - K;

    logic                 r1_v, r2_v, r3_v, r4_v;
    logic [7:0]           r1_g, r2_g, r3_g, r4_g;
    logic signed [DW-1:0] r1_d [3];
    logic signed [PW-1:0] r2_p [9];
    logic signed [SW-1:0] sum [3];
    logic signed [RW-1:0] r3_r [3];
    logic [RW-1:0]        mag [3];
    logic [HW-1:0]        half [3];
    logic [HW-1:0]        r4_m [3];
    logic [2:0]           r4_in;

    assign half[0] = i_half_x;
    assign half[1] = i_half_y;
    assign half[2] = i_half_z;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (i_adv) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
        end
    end

    // Offset from the centre, exact
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_g    <= i_grp;
            r1_d[0] <= DW'(i_px) - DW'(i_ctr_x);
            r1_d[1] <= DW'(i_py) - DW'(i_ctr_y);
            r1_d[2] <= DW'(i_pz) - DW'(i_ctr_z);
        end
    end

    // Matrix entries times offset
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r2_g <= r1_g;
            for (int i = 0; i < 9; i++) begin
                r2_p[i] <= i_mat[i] * r1_d[i % 3];
            end
        end
    end

    // Sum per axis, round to nearest with ties up
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            sum[a] = SW'(r2_p[3*a]) + SW'(r2_p[3*a+1]) + SW'(r2_p[3*a+2])
                     + (SW'(1) <<< (K-1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_g <= r2_g;
            for (int a = 0; a < 3; a++) begin
                r3_r[a] <= RW'(sum[a] >>> K);
            end
        end
    end

    // Magnitude and per-axis bounds
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            mag[a] = r3_r[a][RW-1] ? RW'(-r3_r[a]) : RW'(r3_r[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r4_g <= r3_g;
            for (int a = 0; a < 3; a++) begin
                r4_m[a]  <= mag[a][HW-1:0];
                r4_in[a] <= mag[a] <= RW'(half[a]);
            end
        end
    end

    assign o_valid    = r4_v;
    assign o_grp      = r4_g;
    assign o_m        = r4_m;
    assign o_bnd.in_x = r4_in[0];
    assign o_bnd.in_y = r4_in[1];
    assign o_bnd.in_z = r4_in[2];
endmodule

// File: design/pic_test.sv
// Back pipeline: squares, weighted terms, sum and final shape test
// with the group update (five stages). Uses pic_pkg, pic_mul.
module pic_test #(
    parameter int CW = pic_pkg::COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic [7:0]           i_grp,
    input  logic [CW-2:0]        i_m [3],
    input  pic_pkg::t_bnd        i_bnd,
    input  logic [4*(CW-1)-1:0]  i_kx,
    input  logic [4*(CW-1)-1:0]  i_ky,
    input  logic [4*(CW-1)-1:0]  i_kz,
    input  logic [6*(CW-1)-1:0]  i_rhs,
    input  pic_pkg::t_ctl        i_ctl,
    output logic                 o_valid,
    output logic [7:0]           o_grp,
    output logic                 o_inside
);
    localparam int HW = CW - 1;
    localparam int TW = 6*HW;
    localparam int LW = TW + 2;

    logic                r5_v, r6_v, r7_v, r8_v, r9_v;
    logic [7:0]          r5_g, r6_g, r7_g, r8_g, r9_g;
    pic_pkg::t_bnd       r5_b, r6_b, r7_b, r8_b;
    logic [2*HW-1:0]     r5_sq [3];
    logic [TW-1:0]       prod [3];
    logic [LW-1:0]       r8_sum;
    logic                all_in;
    logic                n_inside;
    logic [7:0]          gmask;
    logic                r9_in;

    // Advance valid bits with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (i_adv) begin
            r5_v <= i_valid;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    // Squares of the magnitudes
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r5_g <= i_grp;
            r5_b <= i_bnd;
            for (int a = 0; a < 3; a++) begin
                r5_sq[a] <= i_m[a] * i_m[a];
            end
        end
    end

    // Weighted terms, two stages inside each multiplier
    pic_mul #(.A_W(4*HW), .B_W(2*HW), .C_W(HW)) u_mul_x (
        .i_clk(i_clk), .i_en(i_adv), .i_a(i_kx), .i_b(r5_sq[0]), .o_p(prod[0])
    );
    pic_mul #(.A_W(4*HW), .B_W(2*HW), .C_W(HW)) u_mul_y (
        .i_clk(i_clk), .i_en(i_adv), .i_a(i_ky), .i_b(r5_sq[1]), .o_p(prod[1])
    );
    pic_mul #(.A_W(4*HW), .B_W(2*HW), .C_W(HW)) u_mul_z (
        .i_clk(i_clk), .i_en(i_adv), .i_a(i_kz), .i_b(r5_sq[2]), .o_p(prod[2])
    );

    // Carry tags alongside the multipliers, then sum the terms
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r6_g   <= r5_g;
            r6_b   <= r5_b;
            r7_g   <= r6_g;
            r7_b   <= r6_b;
            r8_g   <= r7_g;
            r8_b   <= r7_b;
            r8_sum <= LW'(prod[0]) + LW'(prod[1]) + LW'(prod[2]);
        end
    end

    // Final decision per shape
    always_comb begin
        all_in = r8_b.in_x && r8_b.in_y && r8_b.in_z;
        case (i_ctl.shape)
            pic_pkg::SHAPE_BOX: n_inside = all_in;
            pic_pkg::SHAPE_ELL: n_inside = all_in && (r8_sum <= LW'(i_rhs));
            pic_pkg::SHAPE_CYL: n_inside = all_in && (r8_sum <= LW'(i_rhs));
            default:            n_inside = 1'b0;
        endcase
        n_inside = n_inside && i_ctl.enabled;
        if (n_inside && ({29'd0, i_ctl.gbit} < 32'(pic_pkg::GROUP_COUNT))) begin
            gmask = 8'd1 << i_ctl.gbit;
        end else begin
            gmask = 8'd0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r9_g  <= r8_g | gmask;
            r9_in <= n_inside;
        end
    end

    assign o_valid  = r9_v;
    assign o_grp    = r9_g;
    assign o_inside = r9_in;
endmodule
